### rtl/avsaec_pkg.sv
// ----------------------------------------------------------------------------
// avsaec_pkg
// shared types and constants of the avs+ aec bin decoder
// ----------------------------------------------------------------------------
package avsaec_pkg;

  localparam int CTX_COUNT_DEF  = 512;
  localparam int BUF_BITS_DEF   = 64;

  localparam logic [2:0] KIND_PUSH  = 3'd0;
  localparam logic [2:0] KIND_INIT  = 3'd1;
  localparam logic [2:0] KIND_REG   = 3'd2;
  localparam logic [2:0] KIND_TWO   = 3'd3;
  localparam logic [2:0] KIND_BYP   = 3'd4;
  localparam logic [2:0] KIND_STUFF = 3'd5;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_UNDER = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic       mps;
    logic [1:0] cycno;
    logic [9:0] lgpmps;
  } ctx_t;

  localparam ctx_t CTX_RESET = '{mps: 1'b0, cycno: 2'd0, lgpmps: 10'd1023};

  typedef enum logic [3:0] {
    S_IDLE,
    S_CLEAR,
    S_RD,
    S_DECIDE,
    S_RNORM,
    S_VNORM,
    S_INIT_LOAD,
    S_INIT_NORM,
    S_WB_A,
    S_WB_B,
    S_OUT
  } state_t;

  // context update after a decoded bin
  function automatic ctx_t adapt(input logic bin, input ctx_t e);
    ctx_t       r;
    logic [10:0] lg;
    logic [1:0]  cyc;
    logic [10:0] inc;
    r   = e;
    cyc = e.cycno;
    lg  = {1'b0, e.lgpmps};
    if (bin != e.mps) begin
      r.cycno = (cyc <= 2'd2) ? cyc + 2'd1 : 2'd3;
      if (cyc <= 2'd1) inc = 11'd197;
      else if (cyc == 2'd2) inc = 11'd95;
      else inc = 11'd46;
      lg = lg + inc;
      if (lg > 11'd1023) begin
        lg    = 11'd2047 - lg;
        r.mps = ~e.mps;
      end
    end else begin
      if (cyc == 2'd0) r.cycno = 2'd1;
      if (cyc <= 2'd1) lg = lg - (lg >> 3) - (lg >> 5);
      else if (cyc == 2'd2) lg = lg - (lg >> 4) - (lg >> 6);
      else lg = lg - (lg >> 5) - (lg >> 7);
    end
    r.lgpmps = lg[9:0];
    return r;
  endfunction

endpackage

### rtl/avs_context_binary_arith_decoder_top.sv
// ----------------------------------------------------------------------------
// avs_context_binary_arith_decoder_top
// avs+ logarithmic-range aec bin decoder with context memory and bit buffer
// ----------------------------------------------------------------------------
// One request in, one result out; the next request is taken only once the
// result has left. A byte push or an unused kind goes straight to the result,
// and a bypass or stuffing bin that decodes the most probable symbol passes
// the decision state first. A less probable symbol adds a range and then an
// offset renormalisation state, each repeated for every bit it shifts in. A
// regular bin adds one context read and one write-back; a two-context bin
// reads and writes both contexts through the single-port context memory.
// Init sweeps the context memory one entry a cycle, loads nine offset bits
// and then normalises one bit a cycle; the same sweep runs after reset, during
// which no request is taken. A result is held until out_ready takes it.
module avs_context_binary_arith_decoder_top #(
  parameter int CTX_COUNT = avsaec_pkg::CTX_COUNT_DEF,
  parameter int BIT_BUFFER_BITS = avsaec_pkg::BUF_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [2:0] kind,
  input  logic [7:0] data_byte,
  input  logic [8:0] ctx_first,
  input  logic [8:0] ctx_second,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       bin,
  output logic [1:0] status,
  output logic [6:0] bits_held
);
  import avsaec_pkg::*;

  localparam int CW = $clog2(CTX_COUNT);
  localparam int BW = $clog2(BIT_BUFFER_BITS + 1);
  localparam int PW = $clog2(BIT_BUFFER_BITS);

  ctx_t ctx_mem [CTX_COUNT];
  ctx_t rd_data;
  logic [CW-1:0] mem_addr;
  logic mem_we;
  ctx_t mem_wd;

  state_t state, state_next;
  logic [2:0] kind_r;
  logic [CW-1:0] ia, ib;
  ctx_t ca, cb;
  logic rd_second;
  logic [CW-1:0] clr_cnt;
  logic [BIT_BUFFER_BITS-1:0] buf_r;
  logic [BW-1:0] cnt;
  logic [6:0] rs, os;
  logic [7:0] rt, ot;
  logic [8:0] rlps;
  logic [8:0] v;
  logic [3:0] ld_cnt;
  logic underflow;
  logic dbin;
  logic pred_r;
  logic [9:0] lg_r;
  logic res_bin;
  logic [1:0] res_st;

  // bit fetch
  logic cur_bit;
  logic take_bit;
  logic [PW-1:0] rd_pos;
  always_comb begin
    rd_pos = PW'(cnt - BW'(1));
    cur_bit = (cnt != '0) ? buf_r[rd_pos] : 1'b0;
  end

  // context memory
  always_ff @(posedge clk) begin
    if (mem_we) ctx_mem[mem_addr] <= mem_wd;
    rd_data <= ctx_mem[mem_addr];
  end

  // two-context prediction, second context straight from the read port
  logic [9:0] la, lb, lg_two;
  logic [10:0] lsum;
  logic pred_two;
  always_comb begin
    la = ca.lgpmps;
    lb = rd_data.lgpmps;
    lsum = {1'b0, la} + {1'b0, lb};
    lg_two = lsum[10:1];
    pred_two = ca.mps;
    if (ca.mps != rd_data.mps) begin
      if (la < lb) begin
        pred_two = ca.mps;
        lg_two = 10'd1023 - ((lb - la) >> 1);
      end else begin
        pred_two = rd_data.mps;
        lg_two = 10'd1023 - ((la - lb) >> 1);
      end
    end
  end

  // decision arithmetic
  logic [7:0] q;
  logic [7:0] rs2;
  logic [8:0] rt2;
  logic sflag, lps;
  always_comb begin
    q = lg_r[9:2];
    if (rt >= q) begin
      rs2 = {1'b0, rs};
      rt2 = {1'b0, rt} - {1'b0, q};
      sflag = 1'b0;
    end else begin
      rs2 = {1'b0, rs} + 8'd1;
      rt2 = 9'd256 + {1'b0, rt} - {1'b0, q};
      sflag = 1'b1;
    end
    lps = (rs2 > {1'b0, os}) || ((rs2 == {1'b0, os}) && ({1'b0, ot} >= rt2));
  end

  logic [9:0] v_lps;
  always_comb begin
    if (rs2 == {1'b0, os}) v_lps = {2'b0, ot} - {1'b0, rt2};
    else v_lps = 10'd256 + {1'b0, ot, cur_bit} - {1'b0, rt2};
  end

  always_comb begin
    state_next = state;
    in_ready = 1'b0;
    mem_addr = ia;
    mem_we = 1'b0;
    mem_wd = ca;
    take_bit = 1'b0;
    case (state)
      S_CLEAR: begin
        mem_addr = clr_cnt;
        mem_we = 1'b1;
        mem_wd = CTX_RESET;
        if (clr_cnt == CW'(CTX_COUNT - 1)) state_next = (kind_r == KIND_INIT) ? S_INIT_LOAD : S_IDLE;
      end
      S_IDLE: begin
        in_ready = 1'b1;
        mem_addr = CW'(ctx_first);
        if (in_valid) begin
          case (kind)
            KIND_PUSH: state_next = S_OUT;
            KIND_INIT: state_next = S_CLEAR;
            KIND_REG, KIND_TWO: state_next = S_RD;
            KIND_BYP, KIND_STUFF: state_next = S_DECIDE;
            default: state_next = S_OUT;
          endcase
        end
      end
      S_RD: begin
        mem_addr = ib;
        state_next = (kind_r == KIND_TWO && !rd_second) ? S_RD : S_DECIDE;
      end
      S_DECIDE: begin
        if (lps) begin
          take_bit = (rs2 != {1'b0, os});
          state_next = S_RNORM;
        end else begin
          state_next = (kind_r == KIND_REG || kind_r == KIND_TWO) ? S_WB_A : S_OUT;
        end
      end
      S_RNORM: begin
        if (rlps != 9'd0 && rlps < 9'h100) take_bit = 1'b1;
        else state_next = S_VNORM;
      end
      S_VNORM: begin
        if (v < 9'h100 && os < 7'd127) take_bit = 1'b1;
        else state_next = (kind_r == KIND_REG || kind_r == KIND_TWO) ? S_WB_A : S_OUT;
      end
      S_INIT_LOAD: begin
        take_bit = 1'b1;
        if (ld_cnt == 4'd8) state_next = S_INIT_NORM;
      end
      S_INIT_NORM: begin
        if (!v[8] && os < 7'd127) take_bit = 1'b1;
        else state_next = S_OUT;
      end
      S_WB_A: begin
        mem_addr = ia;
        mem_we = 1'b1;
        mem_wd = adapt(dbin, ca);
        state_next = (kind_r == KIND_TWO) ? S_WB_B : S_OUT;
      end
      S_WB_B: begin
        mem_addr = ib;
        mem_we = 1'b1;
        mem_wd = (ib == ia) ? adapt(dbin, adapt(dbin, ca)) : adapt(dbin, cb);
        state_next = S_OUT;
      end
      S_OUT: begin
        if (out_ready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      kind_r <= KIND_PUSH;
      clr_cnt <= '0;
      cnt <= '0;
      rs <= '0;
      rt <= 8'd255;
      os <= '0;
      ot <= '0;
      underflow <= 1'b0;
      rd_second <= 1'b0;
    end else begin
      state <= state_next;
      if (take_bit) begin
        if (cnt == '0) underflow <= 1'b1;
        else cnt <= cnt - BW'(1);
      end
      case (state)
        S_CLEAR: clr_cnt <= clr_cnt + CW'(1);
        S_IDLE: if (in_valid) begin
          kind_r <= kind;
          ia <= CW'(ctx_first);
          ib <= CW'(ctx_second);
          underflow <= 1'b0;
          rd_second <= 1'b0;
          clr_cnt <= '0;
          ld_cnt <= '0;
          res_st <= ST_OK;
          res_bin <= 1'b0;
          dbin <= 1'b0;
          pred_r <= 1'b0;
          lg_r <= (kind == KIND_STUFF) ? 10'd4 : 10'd1023;
          if (kind == KIND_PUSH) begin
            if (32'(cnt) + 8 > BIT_BUFFER_BITS) res_st <= ST_FULL;
            else begin
              buf_r <= (buf_r << 8) | BIT_BUFFER_BITS'(data_byte);
              cnt <= cnt + BW'(8);
            end
          end
        end
        S_RD: begin
          rd_second <= 1'b1;
          if (!rd_second) begin
            ca <= rd_data;
            pred_r <= rd_data.mps;
            lg_r <= rd_data.lgpmps;
          end else begin
            cb <= rd_data;
          end
        end
        S_DECIDE: begin
          if (lps) begin
            dbin <= ~pred_r;
            rlps <= sflag ? 9'({1'b0, rt} + {1'b0, q}) : {1'b0, q};
            // top bit kept sticky once the offset reaches 256
            v <= {v_lps[9] | v_lps[8], v_lps[7:0]};
            os <= '0;
          end else begin
            dbin <= pred_r;
            rs <= rs2[6:0];
            rt <= rt2[7:0];
          end
        end
        S_RNORM: begin
          if (rlps != 9'd0 && rlps < 9'h100) begin
            rlps <= rlps << 1;
            v <= {v[8] | v[7], v[6:0], cur_bit};
          end else begin
            rs <= '0;
            rt <= rlps[7:0];
          end
        end
        S_VNORM: begin
          if (v < 9'h100 && os < 7'd127) begin
            os <= os + 7'd1;
            v <= {v[7:0], cur_bit};
          end else ot <= v[7:0];
        end
        S_INIT_LOAD: begin
          if (ld_cnt == 4'd0) begin
            rs <= '0;
            rt <= 8'hFF;
            os <= '0;
            v <= {8'd0, cur_bit};
          end else v <= {v[7:0], cur_bit};
          ld_cnt <= ld_cnt + 4'd1;
        end
        S_INIT_NORM: begin
          if (!v[8] && os < 7'd127) begin
            v <= {v[7:0], cur_bit};
            os <= os + 7'd1;
          end else ot <= v[7:0];
        end
        default: ;
      endcase
      if (state == S_RD && rd_second) begin
        pred_r <= pred_two;
        lg_r <= lg_two;
      end
      if (state_next == S_OUT && state != S_OUT) begin
        if (state == S_DECIDE) res_bin <= lps ? ~pred_r : pred_r;
        else if (state == S_VNORM || state == S_WB_A || state == S_WB_B) res_bin <= dbin;
      end
    end
  end

  assign out_valid = (state == S_OUT);
  assign bin = res_bin;
  assign status = (res_st == ST_OK && underflow) ? ST_UNDER : res_st;
  assign bits_held = 7'(cnt);

`ifndef NO_ASSERTIONS
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(bin)) else $error("result changed");
  a_excl: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid)) else $error("busy overlap");
  a_cnt: assert property (@(posedge clk) disable iff (rst)
    32'(cnt) <= BIT_BUFFER_BITS) else $error("bit count overflow");
`endif

endmodule
